FILE: sv/asc_pkg.sv
// ----------------------------------------------------------------------------
// asc_pkg
// Types and constants shared by the array subscript classifier.
// ----------------------------------------------------------------------------
package asc_pkg;

  localparam int MAX_LEN   = 4096;
  localparam int MAX_DEPTH = 255;

  localparam int POS_W   = $clog2(MAX_LEN);
  localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
  localparam int CNT_W   = POS_W + 1;
  localparam int OFS_W   = 12;

  localparam logic [7:0] CH_OPEN  = 8'h5B;  // '['
  localparam logic [7:0] CH_CLOSE = 8'h5D;  // ']'
  localparam logic [7:0] CH_DOT   = 8'h2E;  // '.'
  localparam logic [7:0] CH_SPACE = 8'h20;  // ' '
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef enum logic [1:0] {
    TYPE_INVALID = 2'd0,
    TYPE_NUMBER  = 2'd1,
    TYPE_IDENT   = 2'd2
  } id_type_t;

  typedef enum logic [2:0] {
    CLS_NONE    = 3'd0,
    CLS_NUMERIC = 3'd1,
    CLS_SPACE   = 3'd2,
    CLS_DOT     = 3'd3,
    CLS_OTHER   = 3'd4
  } char_class_t;

  typedef struct packed {
    logic       start_scan;
    logic [7:0] char_byte;
  } asc_in_t;

  typedef struct packed {
    logic [1:0]       id_type;
    logic [OFS_W-1:0] start_offset;
    logic [OFS_W-1:0] end_offset;
  } asc_out_t;

  // Outcome of one processed byte
  typedef struct packed {
    logic     emit;
    asc_out_t res;
  } asc_step_t;

endpackage

FILE: sv/asc_core.sv
// ----------------------------------------------------------------------------
// asc_core
// Scan state and per-byte update; reports a classification when a scan ends.
// ----------------------------------------------------------------------------
module asc_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  asc_pkg::asc_in_t req,
  output asc_pkg::asc_step_t outcome
);
  import asc_pkg::*;

  logic                active_r, active_nxt;
  logic                lead_r, lead_nxt;
  logic [DEPTH_W-1:0]  depth_r, depth_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [POS_W-1:0]    word_start_r, word_start_nxt;
  logic [POS_W-1:0]    last_ns_r, last_ns_nxt;
  logic [POS_W-1:0]    start_pos_r, start_pos_nxt;
  logic                have_ns_r, have_ns_nxt;
  logic [1:0]          num_runs_r, num_runs_nxt;
  logic [CNT_W-1:0]    word_cnt_r, word_cnt_nxt;
  logic [CNT_W-1:0]    dot_cnt_r, dot_cnt_nxt;
  logic                saw_nonnum_r, saw_nonnum_nxt;
  logic                can_ident_r, can_ident_nxt;
  char_class_t         prev_cls_r, prev_cls_nxt;

  logic [7:0]     c;
  logic [POS_W-1:0] p;
  logic           skip;
  logic           fin;
  id_type_t       fin_type;
  logic           is_digit;

  assign c        = req.char_byte;
  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);

  always_comb begin
    active_nxt     = active_r;
    lead_nxt       = lead_r;
    depth_nxt      = depth_r;
    pos_nxt        = pos_r;
    word_start_nxt = word_start_r;
    last_ns_nxt    = last_ns_r;
    start_pos_nxt  = start_pos_r;
    have_ns_nxt    = have_ns_r;
    num_runs_nxt   = num_runs_r;
    word_cnt_nxt   = word_cnt_r;
    dot_cnt_nxt    = dot_cnt_r;
    saw_nonnum_nxt = saw_nonnum_r;
    can_ident_nxt  = can_ident_r;
    prev_cls_nxt   = prev_cls_r;
    skip           = 1'b0;
    fin            = 1'b0;
    fin_type       = TYPE_INVALID;

    // a new scan drops whatever was running
    if (req.start_scan) begin
      active_nxt     = 1'b1;
      lead_nxt       = 1'b1;
      depth_nxt      = '0;
      pos_nxt        = '0;
      word_start_nxt = '0;
      last_ns_nxt    = '0;
      start_pos_nxt  = '0;
      have_ns_nxt    = 1'b0;
      num_runs_nxt   = '0;
      word_cnt_nxt   = CNT_W'(1);
      dot_cnt_nxt    = '0;
      saw_nonnum_nxt = 1'b0;
      can_ident_nxt  = 1'b1;
      prev_cls_nxt   = CLS_NONE;
    end

    p = pos_nxt;

    if (active_nxt) begin
      if (lead_nxt) begin
        if (c == CH_SPACE) begin
          skip = 1'b1;
        end else begin
          lead_nxt       = 1'b0;
          start_pos_nxt  = p;
          word_start_nxt = p;
        end
      end

      if (!skip) begin
        if (c == CH_NUL) begin
          fin = 1'b1;
        end else if (c == CH_OPEN) begin
          if (depth_nxt == DEPTH_W'(MAX_DEPTH)) fin = 1'b1;
          else depth_nxt = depth_nxt + 1'b1;
        end else if (c == CH_CLOSE) begin
          if (depth_nxt == '0) begin
            fin = 1'b1;
            if (!have_ns_nxt || (last_ns_nxt < start_pos_nxt)) begin
              fin_type = TYPE_INVALID;
            end else if (num_runs_nxt == 2'd1 && word_cnt_nxt == CNT_W'(1) &&
                         !saw_nonnum_nxt) begin
              fin_type = TYPE_NUMBER;
            end else if (can_ident_nxt &&
                         ({1'b0, dot_cnt_nxt} + 1'b1) == {1'b0, word_cnt_nxt}) begin
              fin_type = TYPE_IDENT;
            end
          end else begin
            depth_nxt   = depth_nxt - 1'b1;
            last_ns_nxt = p;
            have_ns_nxt = 1'b1;
          end
        end else if (depth_nxt == '0) begin
          if ((prev_cls_nxt == CLS_SPACE || prev_cls_nxt == CLS_DOT) &&
              c != CH_SPACE) begin
            word_start_nxt = p;
          end
          if (c != CH_SPACE) begin
            last_ns_nxt = p;
            have_ns_nxt = 1'b1;
          end

          if (is_digit) begin
            if (p == word_start_nxt) can_ident_nxt = 1'b0;
            if (prev_cls_nxt != CLS_NUMERIC) begin
              prev_cls_nxt = CLS_NUMERIC;
              if (num_runs_nxt != 2'd3) num_runs_nxt = num_runs_nxt + 1'b1;
            end
          end else if (c == CH_SPACE) begin
            prev_cls_nxt = CLS_SPACE;
          end else if (c == CH_DOT) begin
            if (prev_cls_nxt == CLS_DOT) begin
              fin = 1'b1;
            end else begin
              prev_cls_nxt = CLS_DOT;
              dot_cnt_nxt  = dot_cnt_nxt + 1'b1;
            end
          end else begin
            if (prev_cls_nxt == CLS_SPACE || prev_cls_nxt == CLS_DOT)
              word_cnt_nxt = word_cnt_nxt + 1'b1;
            prev_cls_nxt   = CLS_OTHER;
            saw_nonnum_nxt = 1'b1;
          end
        end
      end

      // length limit: last offset must close the scan
      if (!fin) begin
        if (p == POS_W'(MAX_LEN - 1)) fin = 1'b1;
        else pos_nxt = p + 1'b1;
      end

      if (fin) active_nxt = 1'b0;
    end
  end

  always_comb begin
    outcome              = '0;
    outcome.emit         = active_nxt == 1'b0 && fin;
    outcome.res.id_type  = fin_type;
    if (fin_type != TYPE_INVALID) begin
      outcome.res.start_offset = OFS_W'(start_pos_nxt);
      outcome.res.end_offset   = OFS_W'(last_ns_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= 1'b0;
      lead_r       <= 1'b0;
      depth_r      <= '0;
      pos_r        <= '0;
      word_start_r <= '0;
      last_ns_r    <= '0;
      start_pos_r  <= '0;
      have_ns_r    <= 1'b0;
      num_runs_r   <= '0;
      word_cnt_r   <= '0;
      dot_cnt_r    <= '0;
      saw_nonnum_r <= 1'b0;
      can_ident_r  <= 1'b0;
      prev_cls_r   <= CLS_NONE;
    end else if (step) begin
      active_r     <= active_nxt;
      lead_r       <= lead_nxt;
      depth_r      <= depth_nxt;
      pos_r        <= pos_nxt;
      word_start_r <= word_start_nxt;
      last_ns_r    <= last_ns_nxt;
      start_pos_r  <= start_pos_nxt;
      have_ns_r    <= have_ns_nxt;
      num_runs_r   <= num_runs_nxt;
      word_cnt_r   <= word_cnt_nxt;
      dot_cnt_r    <= dot_cnt_nxt;
      saw_nonnum_r <= saw_nonnum_nxt;
      can_ident_r  <= can_ident_nxt;
      prev_cls_r   <= prev_cls_nxt;
    end
  end

endmodule

FILE: sv/array_subscript_classifier.sv
// ----------------------------------------------------------------------------
// array_subscript_classifier
// Byte-stream classifier for the text inside a bracketed subscript.
// ----------------------------------------------------------------------------
//  channel | direction | payload                                   | handshake
//  in_     | input     | start_scan, char_byte                     | valid/ready
//  out_    | output    | id_type, start_offset, end_offset         | valid/ready
//
// One byte per cycle sustained while no result is pending; the byte that ends
// a scan passes the input register, and its result then the result register.
// The per-byte update is combinational against the scan state registers.
// A pending result holds the input register; in_ready drops only then.
// rst_n is synchronous and clears the valid flags and the scan state.
module array_subscript_classifier (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  asc_pkg::asc_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output asc_pkg::asc_out_t  out_data
);
  import asc_pkg::*;

  logic      req_valid_r;
  asc_in_t   req_r;
  logic      out_valid_r;
  asc_out_t  out_data_r;
  logic      out_free;
  logic      step;
  asc_step_t outcome;

  assign out_free = !out_valid_r || out_ready;
  assign step     = req_valid_r && out_free;
  assign in_ready = !req_valid_r || step;

  asc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .req     (req_r),
    .outcome (outcome)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_ready) begin
      req_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) req_r <= in_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= step && outcome.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && outcome.emit) out_data_r <= outcome.res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
